/* rtl/vnn_pkg.sv */
// ----------------------------------------------------------------------------
// vnn_pkg: shared types and constants for the vector normalizer
// Lane count, widths, norm mode codes and the lane result format.
// ----------------------------------------------------------------------------
package vnn_pkg;
  localparam int LANES      = 8;
  localparam int DW         = 16;
  localparam int OW         = 16;
  localparam int CNT_W      = 4;
  localparam int MAG_W      = DW;
  localparam int SQ_W       = 2 * MAG_W + 3;
  localparam int SQRT_W     = SQ_W / 2 + 15;
  localparam int NUM_W      = MAG_W + 29;
  localparam int DEN_W      = SQRT_W + 1;
  localparam int Q_W        = 16;

  typedef enum logic [1:0] {
    MODE_L2  = 2'd0,
    MODE_L1  = 2'd1,
    MODE_MAX = 2'd2,
    MODE_RSV = 2'd3
  } norm_mode_t;

  localparam logic REG_NORM_MODE     = 1'b0;
  localparam logic REG_FEATURE_COUNT = 1'b1;

  typedef logic signed [DW-1:0] elem_t;
  typedef logic signed [OW-1:0] res_t;
endpackage

/* rtl/vnn_if.sv */
// ----------------------------------------------------------------------------
// vnn_row_if / vnn_res_if / vnn_cfg_if: channel interfaces
// Valid/ready channels for input rows, result rows and register writes.
// ----------------------------------------------------------------------------
interface vnn_row_if;
  import vnn_pkg::*;
  logic  valid;
  logic  ready;
  elem_t elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7;
  modport source (output valid, elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7,
                  input ready);
  modport sink (input valid, elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7,
                output ready);
endinterface

interface vnn_res_if;
  import vnn_pkg::*;
  logic valid;
  logic ready;
  res_t out0, out1, out2, out3, out4, out5, out6, out7;
  logic zero_row;
  modport source (output valid, out0, out1, out2, out3, out4, out5, out6, out7, zero_row,
                  input ready);
  modport sink (input valid, out0, out1, out2, out3, out4, out5, out6, out7, zero_row,
                output ready);
endinterface

interface vnn_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/vnn_sqrt.sv */
// ----------------------------------------------------------------------------
// vnn_sqrt: pipelined integer square root
// One result bit per stage, restoring method, on sum_sq << 28.
// ----------------------------------------------------------------------------
module vnn_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [vnn_pkg::SQ_W-1:0]      rad,
  output logic [vnn_pkg::SQRT_W-1:0]    root
);
  import vnn_pkg::*;
  localparam int RW = SQ_W + 28;
  localparam int NS = SQRT_W;

  logic [RW-1:0]     rem_r [NS+1];
  logic [SQRT_W-1:0] r_r   [NS+1];

  always_comb begin
    rem_r[0] = {rad, 28'd0};
    r_r[0]   = '0;
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    localparam int B = NS - 1 - s;
    logic [RW+1:0] trial;
    logic [RW-1:0] rem_n;
    logic [SQRT_W-1:0] r_n;
    logic [RW-1:0] rem_q;
    logic [SQRT_W-1:0] r_q;
    always_comb begin
      trial = ({2'b0, r_r[s]} << (B + 1)) + ((RW + 2)'(1) << (2 * B));
      if ({2'b0, rem_r[s]} >= trial) begin
        rem_n = rem_r[s] - trial[RW-1:0];
        r_n   = r_r[s] | (SQRT_W'(1) << B);
      end else begin
        rem_n = rem_r[s];
        r_n   = r_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= rem_n;
        r_q   <= r_n;
      end
    end
    assign rem_r[s+1] = rem_q;
    assign r_r[s+1]   = r_q;
  end

  assign root = r_r[NS];
endmodule

/* rtl/vnn_div.sv */
// ----------------------------------------------------------------------------
// vnn_div: pipelined lane divider
// Restoring division, one quotient bit per stage, rounds half away from zero.
// ----------------------------------------------------------------------------
module vnn_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [vnn_pkg::NUM_W-1:0]  num,
  input  logic [vnn_pkg::DEN_W-1:0]  den,
  input  logic                       neg_in,
  output vnn_pkg::res_t              res
);
  import vnn_pkg::*;
  localparam int QB = Q_W + 1;
  localparam int NW = NUM_W + 1;

  logic [NW-1:0]    n_r [QB+1];
  logic [DEN_W:0]   d_r [QB+1];
  logic [QB-1:0]    q_r [QB+1];
  logic             s_r [QB+1];

  always_comb begin
    n_r[0] = {num, 1'b0} + NW'(den);
    d_r[0] = {den, 1'b0};
    q_r[0] = '0;
    s_r[0] = neg_in;
  end

  for (genvar s = 0; s < QB; s++) begin : g_st
    localparam int B = QB - 1 - s;
    logic [NW+QB-1:0] sh;
    logic [NW-1:0] n_n;
    logic [QB-1:0] q_n;
    logic [NW-1:0] n_q;
    logic [DEN_W:0] d_q;
    logic [QB-1:0] q_q;
    logic s_q;
    always_comb begin
      sh = (NW + QB)'(d_r[s]) << B;
      if ((NW + QB)'(n_r[s]) >= sh) begin
        n_n = n_r[s] - sh[NW-1:0];
        q_n = q_r[s] | (QB'(1) << B);
      end else begin
        n_n = n_r[s];
        q_n = q_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_q <= n_n;
        d_q <= d_r[s];
        q_q <= q_n;
        s_q <= s_r[s];
      end
    end
    assign n_r[s+1] = n_q;
    assign d_r[s+1] = d_q;
    assign q_r[s+1] = q_q;
    assign s_r[s+1] = s_q;
  end

  logic [Q_W-1:0] qv;
  assign qv  = (d_r[QB] == '0) ? '0 : q_r[QB][Q_W-1:0];
  assign res = s_r[QB] ? res_t'(-qv) : res_t'(qv);
endmodule

/* rtl/vector_norm_normalizer_core.sv */
// ----------------------------------------------------------------------------
// vector_norm_normalizer_core: per-row L2 / L1 / max normalization
// Takes one row of eight signed samples per transfer and returns one result
// row per transfer, one row per cycle sustained while results are taken. The
// pipeline is two reduction stages, a 32-stage square root (bypassed in value
// for L1/max, kept in timing) and 17 divider stages per lane; the square root
// sets most of the depth. The whole pipeline advances together and stalls only
// when the output register is full and not taken. Results are Q1.14.
// ----------------------------------------------------------------------------
module vector_norm_normalizer_core (
  input logic     clk,
  input logic     rst,
  vnn_row_if.sink in_row,
  vnn_res_if.source out_res,
  vnn_cfg_if.sink cfg
);
  import vnn_pkg::*;
  localparam int SQ_LAT = SQRT_W;
  localparam int Q_LAT  = Q_W + 1;
  localparam int DEPTH  = 2 + SQ_LAT + Q_LAT;

  norm_mode_t      mode;
  logic [CNT_W-1:0] fcount;
  logic            en;
  logic [DEPTH-1:0] vld;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_L2;
      fcount <= CNT_W'(LANES);
    end else if (cfg.valid) begin
      if (cfg.index == 8'(REG_NORM_MODE)) begin
        mode <= norm_mode_t'(cfg.data[1:0]);
      end else if (cfg.index == 8'(REG_FEATURE_COUNT)) begin
        fcount <= cfg.data[CNT_W-1:0];
      end
    end
  end

  assign en = !vld[DEPTH-1] || out_res.ready;
  assign in_row.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_row.valid};
    end
  end

  elem_t            x [LANES];
  logic [MAG_W-1:0] mag0 [LANES];
  logic             neg0 [LANES];
  assign x[0] = in_row.elem0;
  assign x[1] = in_row.elem1;
  assign x[2] = in_row.elem2;
  assign x[3] = in_row.elem3;
  assign x[4] = in_row.elem4;
  assign x[5] = in_row.elem5;
  assign x[6] = in_row.elem6;
  assign x[7] = in_row.elem7;

  for (genvar i = 0; i < LANES; i++) begin : g_mag
    always_comb begin
      if (CNT_W'(i) >= fcount) begin
        mag0[i] = '0;
        neg0[i] = 1'b0;
      end else begin
        neg0[i] = x[i][DW-1];
        mag0[i] = x[i][DW-1] ? MAG_W'(-x[i]) : MAG_W'(x[i]);
      end
    end
  end

  // stage 1: lane squares and magnitudes
  logic [MAG_W-1:0]   s1_mag [LANES];
  logic               s1_neg [LANES];
  logic [2*MAG_W-1:0] s1_sq  [LANES];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        s1_mag[i] <= mag0[i];
        s1_neg[i] <= neg0[i];
        s1_sq[i]  <= mag0[i] * mag0[i];
      end
    end
  end

  // stage 2: merge
  logic [SQ_W-1:0]  sum_sq, sum_l1;
  logic [MAG_W-1:0] max_v;
  always_comb begin
    sum_sq = '0;
    sum_l1 = '0;
    max_v  = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_sq = sum_sq + SQ_W'(s1_sq[i]);
      sum_l1 = sum_l1 + SQ_W'(s1_mag[i]);
      if (s1_mag[i] > max_v) max_v = s1_mag[i];
    end
  end

  logic [MAG_W-1:0] s2_mag [LANES];
  logic             s2_neg [LANES];
  logic [SQ_W-1:0]  s2_sq;
  logic [DEN_W-1:0] s2_lin;
  logic             s2_l2;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag <= s1_mag;
      s2_neg <= s1_neg;
      s2_sq  <= sum_sq;
      s2_lin <= (mode == MODE_L1) ? DEN_W'(sum_l1) : DEN_W'(max_v);
      s2_l2  <= (mode == MODE_L2) || (mode == MODE_RSV);
    end
  end

  logic [SQRT_W-1:0] root;
  vnn_sqrt u_sqrt (.clk(clk), .en(en), .rad(s2_sq), .root(root));

  logic [MAG_W-1:0] dl_mag [SQ_LAT][LANES];
  logic             dl_neg [SQ_LAT][LANES];
  logic [DEN_W-1:0] dl_lin [SQ_LAT];
  logic             dl_l2  [SQ_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      dl_mag[0] <= s2_mag;
      dl_neg[0] <= s2_neg;
      dl_lin[0] <= s2_lin;
      dl_l2[0]  <= s2_l2;
      for (int k = 1; k < SQ_LAT; k++) begin
        dl_mag[k] <= dl_mag[k-1];
        dl_neg[k] <= dl_neg[k-1];
        dl_lin[k] <= dl_lin[k-1];
        dl_l2[k]  <= dl_l2[k-1];
      end
    end
  end

  logic [DEN_W-1:0] den;
  assign den = dl_l2[SQ_LAT-1] ? DEN_W'(root) : dl_lin[SQ_LAT-1];

  res_t q [LANES];
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [NUM_W-1:0] num;
    assign num = dl_l2[SQ_LAT-1] ? (NUM_W'(dl_mag[SQ_LAT-1][i]) << 28)
                                 : (NUM_W'(dl_mag[SQ_LAT-1][i]) << 14);
    vnn_div u_div (.clk(clk), .en(en), .num(num), .den(den),
                   .neg_in(dl_neg[SQ_LAT-1][i]), .res(q[i]));
  end

  logic zr [Q_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (den == '0);
      for (int k = 1; k < Q_LAT; k++) zr[k] <= zr[k-1];
    end
  end

  assign out_res.valid    = vld[DEPTH-1];
  assign out_res.out0     = q[0];
  assign out_res.out1     = q[1];
  assign out_res.out2     = q[2];
  assign out_res.out3     = q[3];
  assign out_res.out4     = q[4];
  assign out_res.out5     = q[5];
  assign out_res.out6     = q[6];
  assign out_res.out7     = q[7];
  assign out_res.zero_row = zr[Q_LAT-1];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_res.valid && !out_res.ready |=> out_res.valid)
    else $error("result dropped while stalled");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_res.valid && !out_res.ready |-> !in_row.ready)
    else $error("input taken during output stall");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_res.valid && out_res.zero_row |-> out_res.out0 == '0)
    else $error("zero row with nonzero output");
endmodule
